// File: sv/bta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bta_pkg;

  // Input transaction: kind, then the two operands
  typedef struct packed {
    logic        kind;
    logic [16:0] request_bytes;
    logic [15:0] block_addr;
  } req_t;

  // Output transaction
  typedef struct packed {
    logic [15:0] payload_addr;
    logic [1:0]  status;
  } rsp_t;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_ZERO_SIZE = 2'd1;
  localparam logic [1:0] STATUS_NO_MEMORY = 2'd2;

  // Heap layout constants (bytes)
  localparam int TAG_BYTES     = 8;
  localparam int ALIGN_BYTES   = 16;
  localparam int MIN_BLOCK     = 2 * ALIGN_BYTES;
  localparam int FIRST_PAYLOAD = 16;
  localparam int INIT_BREAK    = 32;
  localparam int RESET_LIMIT   = 65536;

  // Offset adjustment applied by the address unit
  typedef enum logic [1:0] {
    SUB_NONE,
    SUB_TAG,
    SUB_ALIGN
  } addr_sub_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_INIT,
    ST_IDLE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_GROW,
    ST_GROW_WR,
    ST_FREE_WR,
    ST_MRG_RDP,
    ST_MRG_RDN,
    ST_MRG_CHK,
    ST_MRG_WR,
    ST_CARVE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// File: sv/boundary_tag_heap_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// First-fit boundary-tag heap allocator. Each transaction on req (allocate or
// free) yields one transaction on rsp. The tags live in one single-port-style
// RAM that is accessed once per cycle; an item passes a read and a check state
// for each block walked from the prologue, plus the states for growth, merging
// and splitting; the block takes no new item until the result is taken.
// After reset a clearing pass over all HEAP_BYTES/8 tag words, then five
// initialization writes (three if the first chunk does not fit), run before
// the first item is accepted; heap limit writes on cfg are taken at any time.
module boundary_tag_heap_allocator_top #(
  parameter int HEAP_BYTES  = 65536,
  parameter int CHUNK_BYTES = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire bta_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output bta_pkg::rsp_t       rsp,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [16:0]    cfg_data
);
  import bta_pkg::*;

  localparam int DEPTH = HEAP_BYTES / TAG_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(HEAP_BYTES) + 1;
  localparam int OW    = $clog2(HEAP_BYTES) + 3;
  localparam int CW    = (OW > 19) ? OW : 19;

  logic [16:0]   lim_cfg;
  logic [CW-1:0] lim;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [TW-1:0] mem_wdata;
  logic [TW-1:0] mem_rdata;

  // Heap limit register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      lim_cfg <= 17'(RESET_LIMIT);
    end else if (cfg_valid) begin
      lim_cfg <= cfg_data;
    end
  end

  // Limit clipped to the store
  assign lim = (CW'(lim_cfg) > CW'(HEAP_BYTES)) ? CW'(HEAP_BYTES) : CW'(lim_cfg);

  bta_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_tags (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_addr),
    .wdata (mem_wdata),
    .raddr (mem_addr),
    .rdata (mem_rdata)
  );

  bta_seq #(
    .HEAP_BYTES  (HEAP_BYTES),
    .CHUNK_BYTES (CHUNK_BYTES),
    .CW          (CW),
    .TW          (TW),
    .AW          (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .lim       (lim),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

endmodule
`default_nettype wire

// File: sv/bta_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module bta_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/bta_addr_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared byte-offset adder: base + add - adjustment, turned into a tag word index
module bta_addr_unit #(
  parameter int CW = 19,
  parameter int AW = 13
) (
  input  wire logic [CW-1:0]            base,
  input  wire logic [CW-1:0]            add,
  input  wire bta_pkg::addr_sub_t       sub,
  output logic      [AW-1:0]            index
);
  import bta_pkg::*;

  logic [CW-1:0] adj;
  logic [CW-1:0] offset;

  always_comb begin
    case (sub)
      SUB_TAG:   adj = CW'(TAG_BYTES);
      SUB_ALIGN: adj = CW'(ALIGN_BYTES);
      default:   adj = '0;
    endcase
    offset = base + add - adj;
  end

  assign index = offset[AW+2:3];

endmodule
`default_nettype wire

// File: sv/bta_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// Allocator sequencer: tag walk, growth, merge and split, one tag access a cycle
module bta_seq #(
  parameter int HEAP_BYTES  = 65536,
  parameter int CHUNK_BYTES = 4096,
  parameter int CW          = 19,
  parameter int TW          = 17,
  parameter int AW          = 13
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire bta_pkg::req_t   req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output bta_pkg::rsp_t        rsp,
  input  wire logic [CW-1:0]   lim,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_addr,
  output logic [TW-1:0]        mem_wdata,
  input  wire logic [TW-1:0]   mem_rdata
);
  import bta_pkg::*;

  // Chunk rounded the way growth rounds it
  localparam int CHUNK_RG  = (((CHUNK_BYTES / TAG_BYTES) + 1) / 2) * 2 * TAG_BYTES;
  localparam int INIT_LIM  = (HEAP_BYTES < RESET_LIMIT) ? HEAP_BYTES : RESET_LIMIT;
  localparam bit INIT_FITS = (CHUNK_RG <= INIT_LIM - INIT_BREAK);
  localparam int DEPTH     = HEAP_BYTES / TAG_BYTES;

  state_t          state, state_next;
  logic [2:0]      step, step_next;
  logic [AW-1:0]   clr, clr_next;
  logic [CW-1:0]   brk, brk_next;
  logic [CW-1:0]   p, p_next;
  logic [CW-1:0]   sz, sz_next;
  logic [CW-1:0]   need, need_next;
  logic [CW-1:0]   prev_sz, prev_sz_next;
  logic            prev_used, prev_used_next;
  logic [CW-1:0]   wa0, wa0_next;
  logic [CW-1:0]   wa1, wa1_next;
  logic            kind, kind_next;
  logic [CW-1:0]   faddr, faddr_next;
  rsp_t            rsp_next;
  logic            rsp_valid_next;

  logic [CW-1:0]   a_base, a_add;
  addr_sub_t       a_sub;

  // Combinational helpers
  logic [CW-1:0]   tag_sz;
  logic            tag_used;
  logic [CW-1:0]   grow_bytes;
  logic            split;
  logic [CW-1:0]   carve_sz;
  logic [CW-1:0]   msz;

  assign tag_sz   = CW'({mem_rdata[TW-1:4], 4'b0000});
  assign tag_used = mem_rdata[0];
  assign grow_bytes = (need > CW'(CHUNK_RG)) ? need : CW'(CHUNK_RG);
  assign split    = (sz - need) >= CW'(MIN_BLOCK);
  assign carve_sz = split ? need : sz;

  bta_addr_unit #(.CW(CW), .AW(AW)) u_addr (
    .base  (a_base),
    .add   (a_add),
    .sub   (a_sub),
    .index (mem_addr)
  );

  // State and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      step      <= '0;
      clr       <= '0;
      brk       <= CW'(INIT_BREAK);
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      clr       <= clr_next;
      brk       <= brk_next;
      rsp_valid <= rsp_valid_next;
    end
    p         <= p_next;
    sz        <= sz_next;
    need      <= need_next;
    prev_sz   <= prev_sz_next;
    prev_used <= prev_used_next;
    wa0       <= wa0_next;
    wa1       <= wa1_next;
    kind      <= kind_next;
    faddr     <= faddr_next;
    rsp       <= rsp_next;
  end

  // Next state and tag port control
  always_comb begin
    state_next     = state;
    step_next      = step;
    clr_next       = clr;
    brk_next       = brk;
    p_next         = p;
    sz_next        = sz;
    need_next      = need;
    prev_sz_next   = prev_sz;
    prev_used_next = prev_used;
    wa0_next       = wa0;
    wa1_next       = wa1;
    kind_next      = kind;
    faddr_next     = faddr;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid;
    req_ready      = 1'b0;
    mem_we         = 1'b0;
    mem_wdata      = '0;
    a_base         = p;
    a_add          = '0;
    a_sub          = SUB_TAG;
    msz            = '0;

    case (state)
      // Zero the tag store, one word a cycle
      ST_CLEAR: begin
        mem_we = 1'b1;
        a_base = CW'({clr, 3'b000});
        a_sub  = SUB_NONE;
        clr_next = clr + 1'b1;
        if (clr == AW'(DEPTH - 1)) begin
          state_next = ST_INIT;
          step_next  = '0;
        end
      end

      // Prologue, first chunk and epilogue
      ST_INIT: begin
        mem_we    = 1'b1;
        step_next = step + 3'd1;
        case (step)
          3'd0: begin
            a_base    = CW'(FIRST_PAYLOAD);
            mem_wdata = TW'(ALIGN_BYTES + 1);
          end
          3'd1: begin
            a_base    = CW'(FIRST_PAYLOAD + TAG_BYTES);
            mem_wdata = TW'(ALIGN_BYTES + 1);
          end
          3'd2: begin
            a_base    = CW'(INIT_BREAK);
            mem_wdata = INIT_FITS ? TW'(CHUNK_RG) : TW'(1);
            if (!INIT_FITS) begin
              brk_next   = CW'(INIT_BREAK);
              state_next = ST_IDLE;
            end
          end
          3'd3: begin
            a_base    = CW'(INIT_BREAK + CHUNK_RG);
            a_sub     = SUB_ALIGN;
            mem_wdata = TW'(CHUNK_RG);
          end
          default: begin
            a_base     = CW'(INIT_BREAK + CHUNK_RG);
            mem_wdata  = TW'(1);
            brk_next   = CW'(INIT_BREAK + CHUNK_RG);
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          kind_next  = req.kind;
          faddr_next = CW'(req.block_addr);
          p_next     = CW'(FIRST_PAYLOAD);
          if (req.request_bytes <= 17'(ALIGN_BYTES)) begin
            need_next = CW'(MIN_BLOCK);
          end else begin
            need_next = (CW'(req.request_bytes) + CW'(MIN_BLOCK - 1))
                        & ~CW'(ALIGN_BYTES - 1);
          end
          if (req.kind == KIND_ALLOC && req.request_bytes == '0) begin
            rsp_next       = '{payload_addr: '0, status: STATUS_ZERO_SIZE};
            rsp_valid_next = 1'b1;
            state_next     = ST_DONE;
          end else begin
            state_next = ST_WALK_RD;
          end
        end
      end

      // Read the header of the block at p
      ST_WALK_RD: begin
        if (p >= brk) begin
          if (kind == KIND_ALLOC) begin
            state_next = ST_GROW;
          end else begin
            rsp_next       = '{payload_addr: '0, status: STATUS_OK};
            rsp_valid_next = 1'b1;
            state_next     = ST_DONE;
          end
        end else begin
          state_next = ST_WALK_CHK;
        end
      end

      ST_WALK_CHK: begin
        p_next     = p + tag_sz;
        state_next = ST_WALK_RD;
        if (kind == KIND_ALLOC) begin
          if (tag_sz == '0) begin
            p_next     = p;
            state_next = ST_GROW;
          end else if (!tag_used && tag_sz >= need) begin
            p_next     = p;
            sz_next    = tag_sz;
            step_next  = '0;
            state_next = ST_CARVE;
          end
        end else begin
          if (tag_sz == '0 || p > faddr ||
              (p == faddr && (p == CW'(FIRST_PAYLOAD) || !tag_used))) begin
            rsp_next       = '{payload_addr: '0, status: STATUS_OK};
            rsp_valid_next = 1'b1;
            state_next     = ST_DONE;
          end else if (p == faddr) begin
            p_next     = p;
            sz_next    = tag_sz;
            step_next  = '0;
            state_next = ST_FREE_WR;
          end
        end
      end

      // Extend the break under the limit
      ST_GROW: begin
        if (brk > lim || grow_bytes > lim - brk) begin
          rsp_next       = '{payload_addr: '0, status: STATUS_NO_MEMORY};
          rsp_valid_next = 1'b1;
          state_next     = ST_DONE;
        end else begin
          p_next     = brk;
          sz_next    = grow_bytes;
          brk_next   = brk + grow_bytes;
          step_next  = '0;
          state_next = ST_GROW_WR;
        end
      end

      // New block header, footer, then the moved epilogue
      ST_GROW_WR: begin
        mem_we    = 1'b1;
        step_next = step + 3'd1;
        mem_wdata = TW'(sz);
        case (step)
          3'd0: a_base = p;
          3'd1: begin
            a_add = sz;
            a_sub = SUB_ALIGN;
          end
          default: begin
            a_add      = sz;
            mem_wdata  = TW'(1);
            state_next = ST_MRG_RDP;
          end
        endcase
      end

      // Clear the allocated bit in header and footer
      ST_FREE_WR: begin
        mem_we    = 1'b1;
        step_next = step + 3'd1;
        mem_wdata = TW'(sz);
        if (step == 3'd0) begin
          a_base = p;
        end else begin
          a_add      = sz;
          a_sub      = SUB_ALIGN;
          state_next = ST_MRG_RDP;
        end
      end

      // Previous block footer
      ST_MRG_RDP: begin
        a_sub      = SUB_ALIGN;
        state_next = ST_MRG_RDN;
      end

      // Capture previous, read next header
      ST_MRG_RDN: begin
        prev_sz_next   = tag_sz;
        prev_used_next = tag_used;
        a_add          = sz;
        state_next     = ST_MRG_CHK;
      end

      // Four-way merge decision
      ST_MRG_CHK: begin
        step_next = '0;
        if (prev_used && tag_used) begin
          state_next = (kind == KIND_ALLOC) ? ST_CARVE : ST_DONE;
          if (kind != KIND_ALLOC) begin
            rsp_next       = '{payload_addr: '0, status: STATUS_OK};
            rsp_valid_next = 1'b1;
          end
        end else begin
          if (prev_used) begin
            msz      = sz + tag_sz;
            wa0_next = p - CW'(TAG_BYTES);
            wa1_next = p + msz - CW'(ALIGN_BYTES);
          end else if (tag_used) begin
            msz      = sz + prev_sz;
            wa0_next = p + sz - CW'(ALIGN_BYTES);
            wa1_next = p - prev_sz - CW'(TAG_BYTES);
            p_next   = p - prev_sz;
          end else begin
            msz      = sz + prev_sz + tag_sz;
            wa0_next = p - prev_sz - CW'(TAG_BYTES);
            wa1_next = p + sz + tag_sz - CW'(ALIGN_BYTES);
            p_next   = p - prev_sz;
          end
          sz_next    = msz;
          state_next = ST_MRG_WR;
        end
      end

      ST_MRG_WR: begin
        mem_we    = 1'b1;
        mem_wdata = TW'(sz);
        a_sub     = SUB_NONE;
        step_next = step + 3'd1;
        if (step == 3'd0) begin
          a_base = wa0;
        end else begin
          a_base    = wa1;
          step_next = '0;
          if (kind == KIND_ALLOC) begin
            state_next = ST_CARVE;
          end else begin
            rsp_next       = '{payload_addr: '0, status: STATUS_OK};
            rsp_valid_next = 1'b1;
            state_next     = ST_DONE;
          end
        end
      end

      // Mark allocated, split off the remainder when large enough
      ST_CARVE: begin
        mem_we    = 1'b1;
        step_next = step + 3'd1;
        case (step)
          3'd0: mem_wdata = TW'(carve_sz) | TW'(1);
          3'd1: begin
            a_add     = carve_sz;
            a_sub     = SUB_ALIGN;
            mem_wdata = TW'(carve_sz) | TW'(1);
          end
          3'd2: begin
            a_add     = need;
            mem_wdata = TW'(sz - need);
          end
          default: begin
            a_add     = sz;
            a_sub     = SUB_ALIGN;
            mem_wdata = TW'(sz - need);
          end
        endcase
        if ((step == 3'd1 && !split) || step == 3'd3) begin
          rsp_next       = '{payload_addr: p[15:0], status: STATUS_OK};
          rsp_valid_next = 1'b1;
          state_next     = ST_DONE;
        end
      end

      ST_DONE: begin
        if (rsp_ready) begin
          rsp_valid_next = 1'b0;
          state_next     = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // A result is held only while the sequencer parks in DONE
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (state == ST_DONE))
    else $error("result valid outside DONE");

  // No new transaction while a result waits
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("ready while result pending");

  // The break never leaves the store
  assert property (@(posedge clk) disable iff (rst)
    brk <= CW'(HEAP_BYTES))
    else $error("break beyond heap");

  // No tag writes while idle or while a result waits
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_DONE) |-> !mem_we)
    else $error("tag write while idle");

endmodule
`default_nettype wire

// File: tb/boundary_tag_heap_allocator_top_test.sv
`timescale 1ns / 1ps
module boundary_tag_heap_allocator_top_test;
  import bta_pkg::*;

  localparam int HEAP_SIZE   = 65536;
  localparam int CHUNK_SIZE  = 4096;
  localparam int TAG_WORDS   = HEAP_SIZE / TAG_BYTES;
  localparam int STALL_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [16:0] cfg_data = '0;

  boundary_tag_heap_allocator_top #(
    .HEAP_BYTES(HEAP_SIZE),
    .CHUNK_BYTES(CHUNK_SIZE)
  ) dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow heap: tag words, break and limit
  int unsigned heap_tags [TAG_WORDS];
  int unsigned break_off;
  int unsigned limit_bytes;

  rsp_t pending_rsp[$];
  int unsigned live_blocks[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit finished = 1'b0;
  int stall_cycles = 0;

  function automatic int unsigned tag_rd(int unsigned a);
    int unsigned i;
    i = a / TAG_BYTES;
    return (i < TAG_WORDS) ? heap_tags[i] : 0;
  endfunction

  function automatic void tag_wr(int unsigned a, int unsigned v);
    int unsigned i;
    i = a / TAG_BYTES;
    if (i < TAG_WORDS) heap_tags[i] = v;
  endfunction

  function automatic int unsigned blk_size(int unsigned p);
    return tag_rd(p - TAG_BYTES) & ~32'(ALIGN_BYTES - 1);
  endfunction

  function automatic bit blk_used(int unsigned p);
    return 1'(tag_rd(p - TAG_BYTES) & 1);
  endfunction

  // Four-case merge with the neighbors; returns the merged payload
  function automatic int unsigned coalesce(int unsigned p);
    int unsigned psz, sz, nx, nsz;
    bit pused, nused;
    psz = tag_rd(p - ALIGN_BYTES) & ~32'(ALIGN_BYTES - 1);
    pused = 1'(tag_rd(p - ALIGN_BYTES) & 1);
    sz = blk_size(p);
    nx = p + sz;
    nused = blk_used(nx);
    nsz = blk_size(nx);
    if (pused && nused) return p;
    if (pused) begin
      sz += nsz;
      tag_wr(p - TAG_BYTES, sz);
      tag_wr(p + sz - ALIGN_BYTES, sz);
      return p;
    end
    if (nused) begin
      sz += psz;
      tag_wr(p + blk_size(p) - ALIGN_BYTES, sz);
      tag_wr(p - psz - TAG_BYTES, sz);
      return p - psz;
    end
    sz += psz + nsz;
    tag_wr(p - psz - TAG_BYTES, sz);
    tag_wr(nx + nsz - ALIGN_BYTES, sz);
    return p - psz;
  endfunction

  function automatic int unsigned round_to_dword(int unsigned bytes);
    return (((bytes / TAG_BYTES) + 1) & ~32'd1) * TAG_BYTES;
  endfunction

  function automatic int unsigned grow_break(int unsigned bytes);
    int unsigned lim, p;
    lim = (limit_bytes > HEAP_SIZE) ? HEAP_SIZE : limit_bytes;
    p = break_off;
    if (bytes == 0 || p > lim || bytes > lim - p) return 0;
    tag_wr(p - TAG_BYTES, bytes);
    tag_wr(p + bytes - ALIGN_BYTES, bytes);
    tag_wr(p + bytes - TAG_BYTES, 1);
    break_off = p + bytes;
    return coalesce(p);
  endfunction

  function automatic int unsigned first_fit_scan(int unsigned need);
    int unsigned p, sz;
    p = FIRST_PAYLOAD;
    for (int n = 0; n <= TAG_WORDS && p < break_off; n++) begin
      sz = blk_size(p);
      if (sz == 0) break;
      if (!blk_used(p) && sz >= need) return p;
      p += sz;
    end
    return 0;
  endfunction

  function automatic bit is_allocated(int unsigned a);
    int unsigned p, sz;
    p = FIRST_PAYLOAD;
    for (int n = 0; n <= TAG_WORDS && p < break_off; n++) begin
      sz = blk_size(p);
      if (sz == 0) break;
      if (p == a) return p != FIRST_PAYLOAD && blk_used(p);
      if (p > a) break;
      p += sz;
    end
    return 1'b0;
  endfunction

  function automatic void split_block(int unsigned p, int unsigned need);
    int unsigned have;
    have = blk_size(p);
    if (have - need >= MIN_BLOCK) begin
      tag_wr(p - TAG_BYTES, need | 1);
      tag_wr(p + need - ALIGN_BYTES, need | 1);
      tag_wr(p + need - TAG_BYTES, have - need);
      tag_wr(p + have - ALIGN_BYTES, have - need);
    end else begin
      tag_wr(p - TAG_BYTES, have | 1);
      tag_wr(p + have - ALIGN_BYTES, have | 1);
    end
  endfunction

  function automatic void heap_init();
    int unsigned unused;
    foreach (heap_tags[i]) heap_tags[i] = 0;
    limit_bytes = RESET_LIMIT;
    tag_wr(8, ALIGN_BYTES | 1);
    tag_wr(16, ALIGN_BYTES | 1);
    tag_wr(24, 1);
    break_off = INIT_BREAK;
    unused = grow_break(round_to_dword(CHUNK_SIZE));
  endfunction

  // Apply one transaction to the shadow heap and return its result
  function automatic rsp_t heap_apply(req_t r);
    rsp_t o;
    int unsigned need, p, ext, sz, unused;
    o = '0;
    o.status = STATUS_OK;
    if (r.kind == KIND_ALLOC) begin
      if (r.request_bytes == 0) begin
        o.status = STATUS_ZERO_SIZE;
        return o;
      end
      if (r.request_bytes <= ALIGN_BYTES) need = MIN_BLOCK;
      else need = ALIGN_BYTES * ((r.request_bytes + 2 * ALIGN_BYTES - 1) / ALIGN_BYTES);
      p = first_fit_scan(need);
      if (p == 0) begin
        ext = (need > CHUNK_SIZE) ? need : CHUNK_SIZE;
        p = grow_break(round_to_dword(ext));
        if (p == 0) begin
          o.status = STATUS_NO_MEMORY;
          return o;
        end
      end
      split_block(p, need);
      o.payload_addr = p[15:0];
      live_blocks.push_back(p);
    end else if (is_allocated(r.block_addr)) begin
      sz = blk_size(r.block_addr);
      tag_wr(r.block_addr - TAG_BYTES, sz);
      tag_wr(r.block_addr + sz - ALIGN_BYTES, sz);
      unused = coalesce(r.block_addr);
    end
    return o;
  endfunction

  // Send one transaction, optionally after a random idle burst
  task automatic send_op(logic kind, int unsigned nbytes, int unsigned addr);
    req_t r;
    r.kind = kind;
    r.request_bytes = nbytes[16:0];
    r.block_addr = addr[15:0];
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    pending_rsp.push_back(heap_apply(r));
  endtask

  task automatic alloc(int unsigned nbytes);
    send_op(KIND_ALLOC, nbytes, $urandom_range(0, 65535));
  endtask

  task automatic release_addr(int unsigned addr);
    send_op(KIND_FREE, $urandom_range(0, 65536), addr);
  endtask

  // Wait until all results are back, then let the block settle
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limit(int unsigned v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v[16:0];
    do @(posedge clk); while (!cfg_ready);
    limit_bytes = v & 32'h1FFFF;
    cfg_valid <= 1'b0;
  endtask

  task automatic free_all_live();
    while (live_blocks.size() != 0) release_addr(live_blocks.pop_front());
  endtask

  // Size edges, zero size, out-of-memory, invalid frees
  task automatic test_size_edges();
    alloc(0);
    alloc(1);
    alloc(16);
    alloc(17);
    alloc(65536);
    alloc(65535);
    alloc(4064);
    alloc(3000);
    release_addr(FIRST_PAYLOAD);
    release_addr(0);
    release_addr(65535);
    release_addr(live_blocks[0]);
    release_addr(live_blocks[0]);   // second free of the same block
    free_all_live();
  endtask

  // All four merge cases
  task automatic test_merges();
    int unsigned a, b, c, d;
    live_blocks.delete();
    alloc(40); alloc(40); alloc(40); alloc(40); alloc(40);
    a = live_blocks[0]; b = live_blocks[1]; c = live_blocks[2]; d = live_blocks[3];
    release_addr(b);   // both neighbors used
    release_addr(a);   // next free
    release_addr(d);   // previous used, next used
    release_addr(c);   // both free
    live_blocks.delete();
    alloc(100);
    alloc(20000);
    alloc(20000);
    alloc(30000);
    free_all_live();
  endtask

  // Limit extremes: minimum, mid, full store
  task automatic test_limits();
    set_limit(4128);
    alloc(5000);
    alloc(60);
    set_limit(8192);
    alloc(5000);
    alloc(5000);
    set_limit(65536);
    alloc(40000);
    free_all_live();
  endtask

  task automatic random_ops(int n);
    int unsigned idx, sz;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0: alloc(0);
        1: alloc($urandom_range(60000, 65536));
        2: release_addr($urandom_range(0, 65535));
        3, 4, 5, 6, 7, 8: begin
          if (live_blocks.size() != 0) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            sz = live_blocks[idx];
            live_blocks.delete(idx);
            release_addr(sz);
          end else alloc($urandom_range(1, 64));
        end
        default: begin
          if (live_blocks.size() > 40) begin
            release_addr(live_blocks.pop_front());
          end else if ($urandom_range(0, 9) == 0) begin
            alloc($urandom_range(1, 12000));
          end else begin
            alloc($urandom_range(1, 300));
          end
        end
      endcase
    end
  endtask

  task automatic test_random();
    random_ops(400);
    set_limit(4128);
    random_ops(300);
    set_limit(4128 + 16 * $urandom_range(0, 3838));
    random_ops(400);
    set_limit(65536);
    drain();
    quiet = 1'b1;
    random_ops(500);
  endtask

  // Result checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result addr=%0d status=%0d", $time,
                 rsp.payload_addr, rsp.status);
        errors++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.payload_addr !== want.payload_addr) begin
          $display("%0t: payload_addr expected %0d actual %0d", $time,
                   want.payload_addr, rsp.payload_addr);
          errors++;
        end
        if (rsp.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, rsp.status);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure in random bursts
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!finished) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    heap_init();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_size_edges();
    test_merges();
    test_limits();
    test_random();
    drain();
    repeat (40) @(posedge clk);
    finished = 1'b1;
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
